// ===== sv/lr_pkg.sv =====
`timescale 1ns / 1ps
// lr_pkg: shared types and constants for the line rasterizer
// no dependencies; imported by every module of the block

package lr_pkg;

  // largest image dimension; size registers saturate here
  localparam int unsigned MAX_DIM  = 4096;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned ERR_W    = 14;
  localparam int unsigned CFG_IDX_W = 1;
  // width of the row times width product plus column
  localparam int unsigned PROD_W   = COORD_W + SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(400);

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;
  } lr_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               outside;
    logic               last;
  } lr_out_t;

  // pixel handed from the walker to the index stage
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  width;
    logic [COLOR_W-1:0] color;
    logic               outside;
    logic               last;
  } lr_pix_t;

endpackage

// ===== sv/lr_walker.sv =====
`timescale 1ns / 1ps
// lr_walker: line setup and Bresenham walk, one pixel per accepted step while a line is active
// depends on lr_pkg

module lr_walker import lr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lr_in_t            in_data,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  output lr_pix_t           pix,
  output logic              pix_valid,
  input  logic              pix_take
);

  // line state
  logic               busy;
  logic               steep_flag;
  logic [COORD_W-1:0] cur_major;
  logic [COORD_W-1:0] cur_minor;
  logic [COORD_W-1:0] major_end;
  logic [COORD_W-1:0] delta_major;
  logic [COORD_W-1:0] delta_minor;
  logic signed [ERR_W-1:0] error_term;
  logic               minor_step_down;
  logic [COLOR_W-1:0] held_color;

  logic accept;
  logic start_fire;
  logic step_fire;

  // setup terms
  logic [COORD_W-1:0] dx, dy;
  logic               steep;
  logic [COORD_W-1:0] maj_a, min_a, maj_b, min_b;
  logic [COORD_W-1:0] s_maj_a, s_min_a, s_maj_b, s_min_b;
  logic [COORD_W-1:0] s_span;

  // walk terms
  logic [COORD_W-1:0] cur_x, cur_y;
  logic               at_last;
  logic               is_outside;
  logic signed [ERR_W-1:0] err_sub;

  // handshake: hold input while a finished pixel cannot move on
  assign in_stall   = pix_valid && !pix_take;
  assign accept     = in_valid && !in_stall;
  assign start_fire = accept && (in_data.command == CMD_START);
  assign step_fire  = accept && (in_data.command == CMD_STEP) && busy;

  // endpoint ordering for a new line
  always_comb begin
    dx = (in_data.start_x > in_data.end_x) ? in_data.start_x - in_data.end_x
                                            : in_data.end_x - in_data.start_x;
    dy = (in_data.start_y > in_data.end_y) ? in_data.start_y - in_data.end_y
                                            : in_data.end_y - in_data.start_y;
    steep = dy > dx;
    if (steep) begin
      maj_a = in_data.start_y;
      min_a = in_data.start_x;
      maj_b = in_data.end_y;
      min_b = in_data.end_x;
    end else begin
      maj_a = in_data.start_x;
      min_a = in_data.start_y;
      maj_b = in_data.end_x;
      min_b = in_data.end_y;
    end
    if (maj_a > maj_b) begin
      s_maj_a = maj_b;
      s_min_a = min_b;
      s_maj_b = maj_a;
      s_min_b = min_a;
    end else begin
      s_maj_a = maj_a;
      s_min_a = min_a;
      s_maj_b = maj_b;
      s_min_b = min_b;
    end
  end

  // major span of the new line
  assign s_span = s_maj_b - s_maj_a;

  // current pixel and error update
  assign cur_x      = steep_flag ? cur_minor : cur_major;
  assign cur_y      = steep_flag ? cur_major : cur_minor;
  assign at_last    = cur_major == major_end;
  assign is_outside = ({1'b0, cur_x} >= width) || ({1'b0, cur_y} >= height);
  assign err_sub    = error_term - $signed({2'b00, delta_minor});

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start_fire) begin
      busy <= 1'b1;
    end else if (step_fire && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      steep_flag      <= steep;
      cur_major       <= s_maj_a;
      cur_minor       <= s_min_a;
      major_end       <= s_maj_b;
      delta_major     <= s_span;
      delta_minor     <= (s_min_a > s_min_b) ? s_min_a - s_min_b : s_min_b - s_min_a;
      error_term      <= $signed({3'b000, s_span[COORD_W-1:1]});
      minor_step_down <= !(s_min_a < s_min_b);
      held_color      <= in_data.line_color;
    end else if (step_fire && !at_last) begin
      if (err_sub < 0) begin
        cur_minor  <= minor_step_down ? cur_minor - COORD_W'(1) : cur_minor + COORD_W'(1);
        error_term <= err_sub + $signed({2'b00, delta_major});
      end else begin
        error_term <= err_sub;
      end
      cur_major <= cur_major + COORD_W'(1);
    end
  end

  // pixel register toward the index stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_take) begin
      pix_valid <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pix.x       <= cur_x;
      pix.y       <= cur_y;
      pix.width   <= width;
      pix.color   <= held_color;
      pix.outside <= is_outside;
      pix.last    <= at_last;
    end
  end

endmodule

// ===== sv/lr_indexer.sv =====
`timescale 1ns / 1ps
// lr_indexer: linear pixel index and result register
// depends on lr_pkg

module lr_indexer import lr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lr_pix_t  pix,
  input  logic     pix_valid,
  output logic     take,
  output logic     out_valid,
  input  logic     out_stall,
  output lr_out_t  out_data
);

  logic [PROD_W-1:0] row_base;
  logic [PROD_W-1:0] index_full;

  // result register frees when empty or being taken
  assign take = !out_valid || !out_stall;

  // y times width plus x
  assign row_base   = PROD_W'(pix.y) * PROD_W'(pix.width);
  assign index_full = row_base + PROD_W'(pix.x);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pix_valid) begin
      out_data.pixel_x     <= pix.x;
      out_data.pixel_y     <= pix.y;
      out_data.pixel_index <= pix.outside ? '0 : index_full[INDEX_W-1:0];
      out_data.pixel_color <= pix.color;
      out_data.outside     <= pix.outside;
      out_data.last        <= pix.last;
    end
  end

endmodule

// ===== sv/line_rasterizer.sv =====
`timescale 1ns / 1ps
// line_rasterizer: Bresenham line generator top level
// depends on lr_pkg, lr_walker, lr_indexer
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------
//   input    | in_valid / in_stall   | in_data   (lr_in_t)
//   output   | out_valid / out_stall | out_data  (lr_out_t)
//   config   | cfg_we                | cfg_index, cfg_data
//
// one command accepted per cycle while in_stall is low; a step while a line is active
// gives a pixel through the walker pixel register, then the index result register.
// start commands and steps while idle give no pixel.
// synchronous reset clears the line and sizes to 400 by 400.
// in_stall rises only while both the pixel register and the result register
// are full and the output is stalled.

module line_rasterizer import lr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lr_in_t               in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lr_out_t              out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] size_sat;
  lr_pix_t           pix;
  logic              pix_valid;
  logic              pix_take;

  // size registers, saturated on write
  assign size_sat = (cfg_data > SIZE_MAX) ? SIZE_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= size_sat;
        REG_IMAGE_HEIGHT: image_height <= size_sat;
        default:          ;
      endcase
    end
  end

  // line walk
  lr_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .width     (image_width),
    .height    (image_height),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_take  (pix_take)
  );

  // index and result register
  lr_indexer u_indexer (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .pix_valid (pix_valid),
    .take      (pix_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/lr_checker.sv =====
`timescale 1ns / 1ps
// lr_checker: port-level checks for the line rasterizer
// depends on lr_pkg; bound to line_rasterizer

module lr_checker import lr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input lr_out_t out_data
);

  // stalled result request stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // pixels outside the image carry a zero index
  a_outside_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outside |-> out_data.pixel_index == '0)
    else $error("outside pixel with nonzero index");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result request right after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_line_rasterizer.sv =====
`timescale 1ns / 1ps
// tb_line_rasterizer: self-checking bench for the Bresenham line rasterizer
// depends on lr_pkg and line_rasterizer; predicts every pixel and checks it in order

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  lr_in_t               in_data;
  logic                 out_valid;
  logic                 out_stall;
  lr_out_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  // shadow of the line walker and the size registers
  logic               line_active = 1'b0;
  logic               walk_steep  = 1'b0;
  logic [COORD_W-1:0] major_pos   = '0;
  logic [COORD_W-1:0] minor_pos   = '0;
  logic [COORD_W-1:0] major_last  = '0;
  int unsigned        major_span  = 0;
  int unsigned        minor_span  = 0;
  int                 err_acc     = 0;
  logic               minor_down  = 1'b0;
  logic [COLOR_W-1:0] held_color  = '0;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;

  lr_out_t pending_pixels[$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      idle_pct;
  int      stall_pct;

  line_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned coord_gap(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic lr_in_t random_payload();
    lr_in_t r;
    r.command    = 1'($urandom_range(1));
    r.start_x    = COORD_W'($urandom_range(4095));
    r.start_y    = COORD_W'($urandom_range(4095));
    r.end_x      = COORD_W'($urandom_range(4095));
    r.end_y      = COORD_W'($urandom_range(4095));
    r.line_color = COLOR_W'($urandom_range(24'hFFFFFF));
    return r;
  endfunction

  // advance the line walk for one accepted request, queue the pixel it gives
  task automatic trace_command(input lr_in_t req);
    int unsigned maj_a, min_a, maj_b, min_b, tmp, w, h, px, py;
    logic steep_now, outside_now;
    lr_out_t pix;
    if (req.command == CMD_START) begin
      steep_now = coord_gap(req.start_y, req.end_y) > coord_gap(req.start_x, req.end_x);
      if (steep_now) begin
        maj_a = req.start_y; min_a = req.start_x; maj_b = req.end_y; min_b = req.end_x;
      end else begin
        maj_a = req.start_x; min_a = req.start_y; maj_b = req.end_x; min_b = req.end_y;
      end
      // order the endpoints so the major coordinate climbs
      if (maj_a > maj_b) begin
        tmp = maj_a; maj_a = maj_b; maj_b = tmp;
        tmp = min_a; min_a = min_b; min_b = tmp;
      end
      walk_steep  = steep_now;
      major_pos   = COORD_W'(maj_a);
      minor_pos   = COORD_W'(min_a);
      major_last  = COORD_W'(maj_b);
      major_span  = maj_b - maj_a;
      minor_span  = coord_gap(min_a, min_b);
      err_acc     = major_span / 2;
      minor_down  = !(min_a < min_b);
      held_color  = req.line_color;
      line_active = 1'b1;
    end else if (line_active) begin
      px = walk_steep ? minor_pos : major_pos;
      py = walk_steep ? major_pos : minor_pos;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      outside_now = (px >= w) || (py >= h);
      pix.pixel_x     = COORD_W'(px);
      pix.pixel_y     = COORD_W'(py);
      pix.pixel_index = outside_now ? '0 : INDEX_W'(py * w + px);
      pix.pixel_color = held_color;
      pix.outside     = outside_now;
      pix.last        = (major_pos == major_last);
      pending_pixels.push_back(pix);
      if (pix.last) begin
        line_active = 1'b0;
      end else begin
        err_acc -= int'(minor_span);
        if (err_acc < 0) begin
          minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
          err_acc += int'(major_span);
        end
        major_pos = major_pos + 1'b1;
      end
    end
  endtask

  // predict at every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      trace_command(in_data);
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t pixel mismatch on %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    lr_out_t exp_pix;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none actual x=%0d y=%0d idx=%0d", $time,
                 out_data.pixel_x, out_data.pixel_y, out_data.pixel_index);
        error_count++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        check_field("pixel_x", exp_pix.pixel_x, out_data.pixel_x);
        check_field("pixel_y", exp_pix.pixel_y, out_data.pixel_y);
        check_field("pixel_index", exp_pix.pixel_index, out_data.pixel_index);
        check_field("pixel_color", exp_pix.pixel_color, out_data.pixel_color);
        check_field("outside", exp_pix.outside, out_data.outside);
        check_field("last", exp_pix.last, out_data.last);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no request or pixel accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no progress, %0d pixels outstanding", $time,
               pending_pixels.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // send one request, with random idle gaps ahead of it
  task automatic send_request(input lr_in_t req);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // start a line and then issue a number of step requests
  task automatic send_line(input int unsigned ax, input int unsigned ay, input int unsigned bx,
                           input int unsigned by, input logic [COLOR_W-1:0] color,
                           input int steps);
    lr_in_t req;
    req = random_payload();
    req.command    = CMD_START;
    req.start_x    = COORD_W'(ax);
    req.start_y    = COORD_W'(ay);
    req.end_x      = COORD_W'(bx);
    req.end_y      = COORD_W'(by);
    req.line_color = color;
    send_request(req);
    repeat (steps) begin
      req = random_payload();
      req.command = CMD_STEP;
      send_request(req);
    end
  endtask

  // stop sending, wait for every pixel, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    width_reg = w;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
  endtask

  // special cases at the reset size of 400 by 400
  task automatic test_directed_lines();
    lr_in_t req;
    req = random_payload();
    req.command = CMD_STEP;
    send_request(req);
    // single pixel, then a step after the line has ended
    send_line(5, 5, 5, 5, 24'hFFFFFF, 2);
    // horizontal, reversed, outside the image
    send_line(4095, 4095, 4092, 4095, 24'h000000, 4);
    // steep with the minor coordinate falling
    send_line(2, 0, 0, 4, 24'h123456, 5);
    // shallow, swapped, minor falling
    send_line(3, 0, 0, 2, 24'hA5A5A5, 4);
    // full-range line abandoned by a new start
    send_line(0, 4095, 4095, 0, 24'h5A5A5A, 2);
    send_line(399, 399, 399, 399, 24'hFF00FF, 1);
  endtask

  // size register extremes, including zero and saturation
  task automatic test_size_registers();
    set_sizes(0, 0);
    send_line(0, 0, 1, 1, 24'h010203, 2);
    set_sizes(1, 1);
    send_line(0, 0, 1, 0, 24'h040506, 2);
    set_sizes(SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM));
    send_line(4095, 4095, 4094, 4094, 24'hFEDCBA, 2);
    set_sizes(13'h1FFF, 13'h1FFF);
    send_line(4094, 4094, 4095, 4095, 24'h0F0F0F, 2);
    set_sizes(13'h1FFF, 1);
    send_line(4095, 0, 4095, 1, 24'hF0F0F0, 2);
  endtask

  // random lines with random content, some broken sequences and noise
  task automatic test_random_traffic(input int items, input int idle, input int stall,
                                     input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    int sent, span, kind, steps, len;
    int ax, ay, bx, by;
    set_sizes(w, h);
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 6) begin
        send_request(random_payload());
        sent++;
      end else begin
        ax = $urandom_range(4095);
        ay = $urandom_range(4095);
        kind = $urandom_range(99);
        span = (kind < 80) ? 15 : 300;
        if (kind < 95) begin
          bx = ax + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(span));
          by = ay + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(span));
          bx = (bx < 0) ? 0 : (bx > 4095) ? 4095 : bx;
          by = (by < 0) ? 0 : (by > 4095) ? 4095 : by;
        end else begin
          bx = $urandom_range(4095);
          by = $urandom_range(4095);
        end
        len = coord_gap(ax, bx);
        if (coord_gap(ay, by) > len) len = coord_gap(ay, by);
        len++;
        // long lines are cut short and left for the next start
        if (kind >= 95 && len > 60) len = $urandom_range(1, 60);
        case ($urandom_range(9))
          0: steps = $urandom_range(len - 1);
          1: steps = len + $urandom_range(1, 3);
          default: steps = len;
        endcase
        send_line(ax, ay, bx, by, COLOR_W'($urandom_range(24'hFFFFFF)), steps);
        sent += 1 + steps;
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_IMAGE_WIDTH;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    width_reg   = SIZE_RESET;
    height_reg  = SIZE_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_lines();
    test_size_registers();
    test_random_traffic(460, 0, 0, SIZE_W'($urandom_range(1, 4096)),
                        SIZE_W'($urandom_range(1, 4096)));
    test_random_traffic(460, 48, 0, SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM));
    test_random_traffic(460, 0, 48, SIZE_W'($urandom_range(1, 600)),
                        SIZE_W'($urandom_range(1, 600)));
    test_random_traffic(460, 31, 31, SIZE_W'($urandom_range(13'h1FFF)),
                        SIZE_W'($urandom_range(13'h1FFF)));
    wait_idle();

    if (pending_pixels.size() != 0) begin
      $display("%0t %0d pixels never arrived", $time, pending_pixels.size());
    end
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
